FILE: rtl/core/c_punctuator_tokenizer_macros.svh
// assertion macros for the c punctuator tokenizer
`ifndef C_PUNCTUATOR_TOKENIZER_MACROS_SVH
`define C_PUNCTUATOR_TOKENIZER_MACROS_SVH

// property checked on every clock edge outside reset
`define CPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cpt_pkg.sv
// shared types and token kind codes for the c punctuator tokenizer
`default_nettype none

package cpt_pkg;

  localparam int CHAR_W          = 21;
  localparam int KIND_W          = 6;
  localparam int MAX_TOKENS      = 3;
  localparam int CPT_QUEUE_DEPTH = 4;

  localparam logic [KIND_W-1:0] K_NE         = 6'd0;
  localparam logic [KIND_W-1:0] K_NOT        = 6'd1;
  localparam logic [KIND_W-1:0] K_MOD_ASSIGN = 6'd2;
  localparam logic [KIND_W-1:0] K_DHASH_DIG  = 6'd3;
  localparam logic [KIND_W-1:0] K_HASH_DIG   = 6'd4;
  localparam logic [KIND_W-1:0] K_RBRACE_DIG = 6'd5;
  localparam logic [KIND_W-1:0] K_MOD        = 6'd6;
  localparam logic [KIND_W-1:0] K_LAND       = 6'd7;
  localparam logic [KIND_W-1:0] K_AND_ASSIGN = 6'd8;
  localparam logic [KIND_W-1:0] K_AND        = 6'd9;
  localparam logic [KIND_W-1:0] K_LPAR       = 6'd10;
  localparam logic [KIND_W-1:0] K_RPAR       = 6'd11;
  localparam logic [KIND_W-1:0] K_MUL_ASSIGN = 6'd12;
  localparam logic [KIND_W-1:0] K_MUL        = 6'd13;
  localparam logic [KIND_W-1:0] K_INC        = 6'd14;
  localparam logic [KIND_W-1:0] K_ADD_ASSIGN = 6'd15;
  localparam logic [KIND_W-1:0] K_ADD        = 6'd16;
  localparam logic [KIND_W-1:0] K_COMMA      = 6'd17;
  localparam logic [KIND_W-1:0] K_DEC        = 6'd18;
  localparam logic [KIND_W-1:0] K_SUB_ASSIGN = 6'd19;
  localparam logic [KIND_W-1:0] K_PTR        = 6'd20;
  localparam logic [KIND_W-1:0] K_SUB        = 6'd21;
  localparam logic [KIND_W-1:0] K_ELLIP      = 6'd22;
  localparam logic [KIND_W-1:0] K_PERIOD     = 6'd23;
  localparam logic [KIND_W-1:0] K_DIV_ASSIGN = 6'd24;
  localparam logic [KIND_W-1:0] K_DIV        = 6'd25;
  localparam logic [KIND_W-1:0] K_RBRACK_DIG = 6'd26;
  localparam logic [KIND_W-1:0] K_COLON      = 6'd27;
  localparam logic [KIND_W-1:0] K_SEMI       = 6'd28;
  localparam logic [KIND_W-1:0] K_LE         = 6'd29;
  localparam logic [KIND_W-1:0] K_SHL_ASSIGN = 6'd30;
  localparam logic [KIND_W-1:0] K_SHL        = 6'd31;
  localparam logic [KIND_W-1:0] K_LBRACK_DIG = 6'd32;
  localparam logic [KIND_W-1:0] K_LBRACE_DIG = 6'd33;
  localparam logic [KIND_W-1:0] K_LT         = 6'd34;
  localparam logic [KIND_W-1:0] K_EQ         = 6'd35;
  localparam logic [KIND_W-1:0] K_ASSIGN     = 6'd36;
  localparam logic [KIND_W-1:0] K_GE         = 6'd37;
  localparam logic [KIND_W-1:0] K_SHR_ASSIGN = 6'd38;
  localparam logic [KIND_W-1:0] K_SHR        = 6'd39;
  localparam logic [KIND_W-1:0] K_GT         = 6'd40;
  localparam logic [KIND_W-1:0] K_QUEST      = 6'd41;
  localparam logic [KIND_W-1:0] K_LBRACK     = 6'd42;
  localparam logic [KIND_W-1:0] K_RBRACK     = 6'd43;
  localparam logic [KIND_W-1:0] K_XOR_ASSIGN = 6'd44;
  localparam logic [KIND_W-1:0] K_XOR        = 6'd45;
  localparam logic [KIND_W-1:0] K_LBRACE     = 6'd46;
  localparam logic [KIND_W-1:0] K_OR_ASSIGN  = 6'd47;
  localparam logic [KIND_W-1:0] K_LOR        = 6'd48;
  localparam logic [KIND_W-1:0] K_OR         = 6'd49;
  localparam logic [KIND_W-1:0] K_RBRACE     = 6'd50;
  localparam logic [KIND_W-1:0] K_TILDE      = 6'd51;
  localparam logic [KIND_W-1:0] K_DHASH      = 6'd52;
  localparam logic [KIND_W-1:0] K_HASH       = 6'd53;
  localparam logic [KIND_W-1:0] K_OTHER      = 6'd54;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_end;
  } cpt_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [CHAR_W-1:0] passed_char;
    logic              last_in_run;
  } cpt_out_t;

  // all tokens caused by one request, oldest in slot zero
  typedef struct packed {
    logic [1:0]                        count;
    logic [MAX_TOKENS-1:0][KIND_W-1:0] kinds;
    logic [CHAR_W-1:0]                 char_code;
  } cpt_bundle_t;

endpackage

`default_nettype wire

FILE: rtl/core/c_punctuator_tokenizer.sv
// top level of the c punctuator tokenizer
//
// input channel: item carries one code point or an end flush; a request is
// taken at a clock edge with push high and full low
// result channel: the oldest token sits on result while empty is low and is
// taken at a clock edge with pop high and empty low
// the front end keeps the partial-punctuator prefix and turns each request
// into zero to three tokens in the cycle it is taken; a bundle queue of
// QUEUE_DEPTH entries feeds the back end, which hands out one token per cycle
// the first token of a request passes through the bundle queue and then the
// output register before it sits on result
// requests are taken one per cycle while each gives at most one token and pop
// is high; a request that gives two or three tokens holds the back end until
// its last token is out, and the bundle queue absorbs the difference
// when the receiver holds pop low, the output register keeps its token, the
// queue fills and full rises; nothing is dropped
// reset (rst, synchronous) clears the prefix to idle and empties the queue
// and output register
`default_nettype none

module c_punctuator_tokenizer #(
  parameter int QUEUE_DEPTH = cpt_pkg::CPT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  cpt_pkg::cpt_in_t  item,
  output logic              empty,
  input  logic              pop,
  output cpt_pkg::cpt_out_t result
);
  import cpt_pkg::*;

  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_empty;
  cpt_bundle_t q_wr;
  cpt_bundle_t q_head;

  cpt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr)
  );

  cpt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  cpt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  assign full = q_full;

endmodule

`default_nettype wire

FILE: rtl/core/cpt_front.sv
// front end: prefix state machine that classifies each request into a token bundle
`default_nettype none

module cpt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpt_pkg::cpt_in_t     item,
  input  logic                 q_full,
  output logic                 q_push,
  output cpt_pkg::cpt_bundle_t q_data
);
  import cpt_pkg::*;

  localparam int ST_W = 5;

  localparam logic [ST_W-1:0] S_IDLE        = 5'd0;
  localparam logic [ST_W-1:0] S_BANG        = 5'd1;
  localparam logic [ST_W-1:0] S_PCT         = 5'd2;
  localparam logic [ST_W-1:0] S_PCT_COL     = 5'd3;
  localparam logic [ST_W-1:0] S_PCT_COL_PCT = 5'd4;
  localparam logic [ST_W-1:0] S_AMP         = 5'd5;
  localparam logic [ST_W-1:0] S_STAR        = 5'd6;
  localparam logic [ST_W-1:0] S_PLUS        = 5'd7;
  localparam logic [ST_W-1:0] S_MINUS       = 5'd8;
  localparam logic [ST_W-1:0] S_DOT         = 5'd9;
  localparam logic [ST_W-1:0] S_DOT_DOT     = 5'd10;
  localparam logic [ST_W-1:0] S_SLASH       = 5'd11;
  localparam logic [ST_W-1:0] S_COL         = 5'd12;
  localparam logic [ST_W-1:0] S_LT          = 5'd13;
  localparam logic [ST_W-1:0] S_LT_LT       = 5'd14;
  localparam logic [ST_W-1:0] S_EQ          = 5'd15;
  localparam logic [ST_W-1:0] S_GT          = 5'd16;
  localparam logic [ST_W-1:0] S_GT_GT       = 5'd17;
  localparam logic [ST_W-1:0] S_CARET       = 5'd18;
  localparam logic [ST_W-1:0] S_PIPE        = 5'd19;
  localparam logic [ST_W-1:0] S_HASH        = 5'd20;

  localparam logic [CHAR_W-1:0] C_BANG   = 21'h21;
  localparam logic [CHAR_W-1:0] C_HASH   = 21'h23;
  localparam logic [CHAR_W-1:0] C_PCT    = 21'h25;
  localparam logic [CHAR_W-1:0] C_AMP    = 21'h26;
  localparam logic [CHAR_W-1:0] C_LPAR   = 21'h28;
  localparam logic [CHAR_W-1:0] C_RPAR   = 21'h29;
  localparam logic [CHAR_W-1:0] C_STAR   = 21'h2A;
  localparam logic [CHAR_W-1:0] C_PLUS   = 21'h2B;
  localparam logic [CHAR_W-1:0] C_COMMA  = 21'h2C;
  localparam logic [CHAR_W-1:0] C_MINUS  = 21'h2D;
  localparam logic [CHAR_W-1:0] C_DOT    = 21'h2E;
  localparam logic [CHAR_W-1:0] C_SLASH  = 21'h2F;
  localparam logic [CHAR_W-1:0] C_COLON  = 21'h3A;
  localparam logic [CHAR_W-1:0] C_SEMI   = 21'h3B;
  localparam logic [CHAR_W-1:0] C_LT     = 21'h3C;
  localparam logic [CHAR_W-1:0] C_EQ     = 21'h3D;
  localparam logic [CHAR_W-1:0] C_GT     = 21'h3E;
  localparam logic [CHAR_W-1:0] C_QUEST  = 21'h3F;
  localparam logic [CHAR_W-1:0] C_LBRACK = 21'h5B;
  localparam logic [CHAR_W-1:0] C_RBRACK = 21'h5D;
  localparam logic [CHAR_W-1:0] C_CARET  = 21'h5E;
  localparam logic [CHAR_W-1:0] C_LBRACE = 21'h7B;
  localparam logic [CHAR_W-1:0] C_PIPE   = 21'h7C;
  localparam logic [CHAR_W-1:0] C_RBRACE = 21'h7D;
  localparam logic [CHAR_W-1:0] C_TILDE  = 21'h7E;

  typedef struct packed {
    logic              hit;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [ST_W-1:0]   next;
  } step_t;

  typedef struct packed {
    logic [1:0]        n;
    logic [KIND_W-1:0] k0;
    logic [KIND_W-1:0] k1;
  } flush_t;

  function automatic step_t take(input logic [KIND_W-1:0] k);
    take = '{hit: 1'b1, emit: 1'b1, kind: k, next: S_IDLE};
  endfunction

  function automatic step_t go(input logic [ST_W-1:0] s);
    go = '{hit: 1'b1, emit: 1'b0, kind: K_OTHER, next: s};
  endfunction

  function automatic step_t extend(input logic [ST_W-1:0] st, input logic [CHAR_W-1:0] c);
    step_t r;
    r = '{hit: 1'b0, emit: 1'b0, kind: K_OTHER, next: st};
    unique case (st)
      S_BANG:    if (c == C_EQ) r = take(K_NE);
      S_PCT: begin
        if (c == C_EQ) r = take(K_MOD_ASSIGN);
        else if (c == C_COLON) r = go(S_PCT_COL);
        else if (c == C_GT) r = take(K_RBRACE_DIG);
      end
      S_PCT_COL: if (c == C_PCT) r = go(S_PCT_COL_PCT);
      S_AMP: begin
        if (c == C_AMP) r = take(K_LAND);
        else if (c == C_EQ) r = take(K_AND_ASSIGN);
      end
      S_STAR:    if (c == C_EQ) r = take(K_MUL_ASSIGN);
      S_PLUS: begin
        if (c == C_PLUS) r = take(K_INC);
        else if (c == C_EQ) r = take(K_ADD_ASSIGN);
      end
      S_MINUS: begin
        if (c == C_MINUS) r = take(K_DEC);
        else if (c == C_EQ) r = take(K_SUB_ASSIGN);
        else if (c == C_GT) r = take(K_PTR);
      end
      S_DOT:     if (c == C_DOT) r = go(S_DOT_DOT);
      S_DOT_DOT: if (c == C_DOT) r = take(K_ELLIP);
      S_SLASH:   if (c == C_EQ) r = take(K_DIV_ASSIGN);
      S_COL:     if (c == C_GT) r = take(K_RBRACK_DIG);
      S_LT: begin
        if (c == C_EQ) r = take(K_LE);
        else if (c == C_LT) r = go(S_LT_LT);
        else if (c == C_COLON) r = take(K_LBRACK_DIG);
        else if (c == C_PCT) r = take(K_LBRACE_DIG);
      end
      S_LT_LT:   if (c == C_EQ) r = take(K_SHL_ASSIGN);
      S_EQ:      if (c == C_EQ) r = take(K_EQ);
      S_GT: begin
        if (c == C_EQ) r = take(K_GE);
        else if (c == C_GT) r = go(S_GT_GT);
      end
      S_GT_GT:   if (c == C_EQ) r = take(K_SHR_ASSIGN);
      S_CARET:   if (c == C_EQ) r = take(K_XOR_ASSIGN);
      S_PIPE: begin
        if (c == C_EQ) r = take(K_OR_ASSIGN);
        else if (c == C_PIPE) r = take(K_LOR);
      end
      S_HASH:    if (c == C_HASH) r = take(K_DHASH);
      default:   r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic step_t start(input logic [CHAR_W-1:0] c);
    step_t r;
    r = '{hit: 1'b1, emit: 1'b0, kind: K_OTHER, next: S_IDLE};
    unique case (c)
      C_BANG:   r.next = S_BANG;
      C_PCT:    r.next = S_PCT;
      C_AMP:    r.next = S_AMP;
      C_STAR:   r.next = S_STAR;
      C_PLUS:   r.next = S_PLUS;
      C_MINUS:  r.next = S_MINUS;
      C_DOT:    r.next = S_DOT;
      C_SLASH:  r.next = S_SLASH;
      C_COLON:  r.next = S_COL;
      C_LT:     r.next = S_LT;
      C_EQ:     r.next = S_EQ;
      C_GT:     r.next = S_GT;
      C_CARET:  r.next = S_CARET;
      C_PIPE:   r.next = S_PIPE;
      C_HASH:   r.next = S_HASH;
      C_LPAR:   r = take(K_LPAR);
      C_RPAR:   r = take(K_RPAR);
      C_COMMA:  r = take(K_COMMA);
      C_SEMI:   r = take(K_SEMI);
      C_QUEST:  r = take(K_QUEST);
      C_LBRACK: r = take(K_LBRACK);
      C_RBRACK: r = take(K_RBRACK);
      C_LBRACE: r = take(K_LBRACE);
      C_RBRACE: r = take(K_RBRACE);
      C_TILDE:  r = take(K_TILDE);
      default:  r = take(K_OTHER);
    endcase
    return r;
  endfunction

  function automatic flush_t flush_of(input logic [ST_W-1:0] st);
    flush_t f;
    f = '{n: 2'd1, k0: K_OTHER, k1: K_OTHER};
    unique case (st)
      S_BANG:        f.k0 = K_NOT;
      S_PCT:         f.k0 = K_MOD;
      S_PCT_COL:     f.k0 = K_HASH_DIG;
      S_PCT_COL_PCT: f = '{n: 2'd2, k0: K_HASH_DIG, k1: K_MOD};
      S_AMP:         f.k0 = K_AND;
      S_STAR:        f.k0 = K_MUL;
      S_PLUS:        f.k0 = K_ADD;
      S_MINUS:       f.k0 = K_SUB;
      S_DOT:         f.k0 = K_PERIOD;
      S_DOT_DOT:     f = '{n: 2'd2, k0: K_PERIOD, k1: K_PERIOD};
      S_SLASH:       f.k0 = K_DIV;
      S_COL:         f.k0 = K_COLON;
      S_LT:          f.k0 = K_LT;
      S_LT_LT:       f.k0 = K_SHL;
      S_EQ:          f.k0 = K_ASSIGN;
      S_GT:          f.k0 = K_GT;
      S_GT_GT:       f.k0 = K_SHR;
      S_CARET:       f.k0 = K_XOR;
      S_PIPE:        f.k0 = K_OR;
      S_HASH:        f.k0 = K_HASH;
      default:       f.n = 2'd0;
    endcase
    return f;
  endfunction

  logic [ST_W-1:0]                   prefix_state;
  logic [ST_W-1:0]                   prefix_state_next;
  logic [MAX_TOKENS-1:0][KIND_W-1:0] kinds_c;
  logic [1:0]                        cnt_c;
  step_t                             ext;
  step_t                             stt;
  flush_t                            fl;
  logic                              accept;

  assign accept = push && !q_full;

  always_comb begin
    ext               = extend(prefix_state, item.char_code);
    stt               = start(item.char_code);
    fl                = flush_of(prefix_state);
    kinds_c           = {MAX_TOKENS{K_OTHER}};
    cnt_c             = 2'd0;
    prefix_state_next = prefix_state;
    if (item.is_end) begin
      kinds_c[0]        = fl.k0;
      kinds_c[1]        = fl.k1;
      cnt_c             = fl.n;
      prefix_state_next = S_IDLE;
    end else if (prefix_state == S_PCT_COL_PCT && item.char_code == C_COLON) begin
      kinds_c[0]        = K_DHASH_DIG;
      cnt_c             = 2'd1;
      prefix_state_next = S_IDLE;
    end else if (prefix_state == S_PCT_COL_PCT &&
                 (item.char_code == C_EQ || item.char_code == C_GT)) begin
      kinds_c[0]        = K_HASH_DIG;
      kinds_c[1]        = (item.char_code == C_EQ) ? K_MOD_ASSIGN : K_RBRACE_DIG;
      cnt_c             = 2'd2;
      prefix_state_next = S_IDLE;
    end else if (ext.hit) begin
      kinds_c[0]        = ext.kind;
      cnt_c             = {1'b0, ext.emit};
      prefix_state_next = ext.next;
    end else begin
      // pending prefix is emitted, then the character starts over from idle
      kinds_c[0]        = fl.k0;
      kinds_c[1]        = fl.k1;
      kinds_c[fl.n]     = stt.kind;
      cnt_c             = fl.n + {1'b0, stt.emit};
      prefix_state_next = stt.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_state <= S_IDLE;
    end else if (accept) begin
      prefix_state <= prefix_state_next;
    end
  end

  assign q_push = accept && (cnt_c != 2'd0);

  always_comb begin
    q_data.count     = cnt_c;
    q_data.kinds     = kinds_c;
    q_data.char_code = item.char_code;
  end

endmodule

`default_nettype wire

FILE: rtl/core/cpt_queue.sv
// short bundle queue between the front end and the back end
`default_nettype none
`include "c_punctuator_tokenizer_macros.svh"

module cpt_queue #(
  parameter int DEPTH = cpt_pkg::CPT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpt_pkg::cpt_bundle_t wr_data,
  output logic                 full,
  input  logic                 pop,
  output cpt_pkg::cpt_bundle_t rd_data,
  output logic                 empty
);
  import cpt_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpt_bundle_t      mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  assign rd_data = mem[rd_ptr];

  `CPT_ASSERT(a_q_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `CPT_ASSERT(a_q_grow, (do_wr && !do_rd) |=> (count == $past(count) + 1'b1), "queue count lost a write")

endmodule

`default_nettype wire

FILE: rtl/core/cpt_back.sv
// back end: serializes token bundles into single results through an output register
`default_nettype none
`include "c_punctuator_tokenizer_macros.svh"

module cpt_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  cpt_pkg::cpt_bundle_t q_head,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output cpt_pkg::cpt_out_t    result
);
  import cpt_pkg::*;

  logic [1:0]        idx;
  logic [1:0]        idx_next;
  logic              out_valid;
  cpt_out_t          out_reg;
  logic              load;
  logic              last;
  logic [KIND_W-1:0] kind_sel;

  assign load     = !out_valid || pop;
  assign kind_sel = q_head.kinds[idx];
  assign last     = (idx == q_head.count - 2'd1);
  assign q_pop    = load && !q_empty && last;
  assign idx_next = last ? 2'd0 : idx + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_reg.token_kind  <= kind_sel;
      out_reg.passed_char <= (kind_sel == K_OTHER) ? q_head.char_code : '0;
      out_reg.last_in_run <= last;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

  `CPT_ASSERT_IMPL(a_idx_range, !q_empty, idx < q_head.count, "token index beyond bundle")
  `CPT_ASSERT_IMPL(a_idle_idx, q_empty, idx == 2'd0, "token index left mid bundle")
  `CPT_ASSERT_IMPL(a_char_zero, out_valid && (out_reg.token_kind != K_OTHER), out_reg.passed_char == '0, "char on punctuator")

endmodule

`default_nettype wire
